@@ sv/acctilt_pkg.sv @@
// ----------------------------------------------------------------------------
// Tilt angle package
// Shared widths, item structures and the arctangent constant table.
// ----------------------------------------------------------------------------
package acctilt_pkg;

    localparam int ROTATION_STAGES = 16;
    localparam int MAX_STAGES      = 24;
    localparam int NSTAGES = (ROTATION_STAGES < MAX_STAGES) ? ROTATION_STAGES : MAX_STAGES;

    // sum of squares: up to 2^31, 32 bits; root with 8 fraction bits: 24 bits
    localparam int SUM_W  = 32;
    localparam int RAD_W  = SUM_W + 16;          // radicand, sum << 16
    localparam int ROOT_W = RAD_W / 2;           // 24 bits
    localparam int CV_W   = 27;                  // signed rotation vector width
    localparam int ANG_W  = 32;                  // signed angle, 30 fraction bits
    localparam int MAG_W  = 31;
    localparam int DEG_SHIFT = 46;
    localparam logic [28:0] DEG_SCALE = 29'd375493621;
    localparam int ANGLE_LIMIT = 9000;
    localparam int TILT_W = 15;

    typedef logic [ANG_W-1:0] atan_tab_t [MAX_STAGES];
    localparam atan_tab_t ATAN_Q30 = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
        32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
        32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
    };

    // one front-end item: numerators and sums of squares for both angles
    typedef struct packed {
        logic signed [15:0] num_x;
        logic signed [15:0] num_y;
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
    } front_item_t;

    typedef struct packed {
        logic signed [TILT_W-1:0] tilt_x;
        logic signed [TILT_W-1:0] tilt_y;
    } result_t;

endpackage

@@ sv/acctilt_front.sv @@
// ----------------------------------------------------------------------------
// Tilt front end
// Accept raw samples, form the squares and sums, and register one item.
// ----------------------------------------------------------------------------
module acctilt_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [15:0]         ax,
    input  logic signed [15:0]         ay,
    input  logic signed [15:0]         az,
    output logic                       out_valid,
    input  logic                       out_ready,
    output acctilt_pkg::front_item_t   out_item
);
    import acctilt_pkg::*;

    logic        sq_valid_reg;
    logic [31:0] sqx_reg, sqy_reg, sqz_reg;
    logic signed [15:0] nx_reg, ny_reg;
    logic        sq_adv;
    logic        valid_reg;
    front_item_t item_reg;

    // stage 1 squares, stage 2 sums; stage 2 stalls on back-pressure, stage 1 only while it is also full
    assign sq_adv   = !valid_reg || out_ready;
    assign in_ready = !sq_valid_reg || sq_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            if (in_ready) sq_valid_reg <= in_valid;
            if (sq_adv)   valid_reg    <= sq_valid_reg;
        end
        if (in_ready && in_valid) begin
            sqx_reg <= 32'(ax * ax);
            sqy_reg <= 32'(ay * ay);
            sqz_reg <= 32'(az * az);
            nx_reg  <= ax;
            ny_reg  <= ay;
        end
        if (sq_adv && sq_valid_reg) begin
            item_reg.num_x <= nx_reg;
            item_reg.num_y <= ny_reg;
            item_reg.sum_x <= sqy_reg + sqz_reg;
            item_reg.sum_y <= sqx_reg + sqz_reg;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

@@ sv/acctilt_fifo.sv @@
// ----------------------------------------------------------------------------
// Tilt item queue
// Two-entry queue that decouples the front end from the rotation pipeline.
// ----------------------------------------------------------------------------
module acctilt_fifo (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  acctilt_pkg::front_item_t in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output acctilt_pkg::front_item_t out_item
);
    import acctilt_pkg::*;

    front_item_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) mem_reg[wp_reg] <= in_item;
    end
endmodule

@@ sv/acctilt_sqrt.sv @@
// ----------------------------------------------------------------------------
// Tilt root pipeline
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module acctilt_sqrt (
    input  logic                                 aclk,
    input  logic                                 adv,
    input  logic [acctilt_pkg::SUM_W-1:0]        sum,
    output logic [acctilt_pkg::ROOT_W-1:0]       root
);
    import acctilt_pkg::*;

    logic [RAD_W-1:0]  rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] res_reg  [ROOT_W+1];
    logic [RAD_W-1:0]  rem_next [ROOT_W];
    logic [ROOT_W-1:0] res_next [ROOT_W];

    // restoring method: stage k tries bit ROOT_W-1-k
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            logic [RAD_W-1:0] trial;
            trial = RAD_W'({res_reg[k], 2'b01}) << (2 * (ROOT_W - 1 - k));
            if (rem_reg[k] >= trial) begin
                rem_next[k] = rem_reg[k] - trial;
                res_next[k] = {res_reg[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k] = rem_reg[k];
                res_next[k] = {res_reg[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= {sum, 16'd0};
            res_reg[0] <= '0;
            for (int k = 0; k < ROOT_W; k++) begin
                rem_reg[k+1] <= rem_next[k];
                res_reg[k+1] <= res_next[k];
            end
        end
    end

    assign root = res_reg[ROOT_W];
endmodule

@@ sv/acctilt_back.sv @@
// ----------------------------------------------------------------------------
// Tilt back end
// Root, vectoring rotation and degree conversion for both angles, with an
// output register and skid stage.
// ----------------------------------------------------------------------------
module acctilt_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  acctilt_pkg::front_item_t in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output acctilt_pkg::result_t     out_res
);
    import acctilt_pkg::*;

    localparam int SQ_LAT = ROOT_W + 1;       // root stages plus input stage
    localparam int LAT    = SQ_LAT + NSTAGES + 4;

    logic adv;
    logic [LAT-1:0] vld_reg;
    logic [ROOT_W-1:0] root_x, root_y;

    // numerators travel alongside the root pipeline
    logic signed [15:0] nx_d_reg [SQ_LAT];
    logic signed [15:0] ny_d_reg [SQ_LAT];

    acctilt_sqrt u_sqrt_x (.aclk(aclk), .adv(adv), .sum(in_item.sum_x), .root(root_x));
    acctilt_sqrt u_sqrt_y (.aclk(aclk), .adv(adv), .sum(in_item.sum_y), .root(root_y));

    // rotation stages: index 0 holds the start vector
    logic signed [CV_W-1:0]  xx_reg [2][NSTAGES+1];
    logic signed [CV_W-1:0]  yy_reg [2][NSTAGES+1];
    logic signed [ANG_W-1:0] aa_reg [2][NSTAGES+1];
    logic [1:0] zr_reg [2][NSTAGES+1];   // {zero denominator, 0}
    logic signed [15:0] nn_reg [2][NSTAGES+1];

    logic [MAG_W-1:0] mag_reg [2];
    logic             neg_reg [2];
    logic             zd_reg [2];
    logic signed [15:0] nf_reg [2];
    logic [59:0]      prod_reg [2];
    logic             neg2_reg [2];
    logic             zd2_reg [2];
    logic signed [15:0] nf2_reg [2];
    result_t          res_reg;

    // skid: output register plus one spare slot
    logic    ov_reg, sv_reg;
    result_t o_reg, s_reg;
    logic    res_valid;

    assign res_valid = vld_reg[LAT-1];
    assign adv       = !sv_reg;
    assign in_ready  = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
            sv_reg  <= 1'b0;
        end else begin
            if (adv) vld_reg <= {vld_reg[LAT-2:0], in_valid};
            if (!ov_reg || out_ready) begin
                ov_reg <= sv_reg || (adv && res_valid);
                sv_reg <= 1'b0;
            end else if (adv && res_valid) begin
                sv_reg <= 1'b1;
            end
        end
        if (!ov_reg || out_ready) begin
            o_reg <= sv_reg ? s_reg : res_reg;
        end else if (adv && res_valid) begin
            s_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_d_reg[0] <= in_item.num_x;
            ny_d_reg[0] <= in_item.num_y;
            for (int k = 1; k < SQ_LAT; k++) begin
                nx_d_reg[k] <= nx_d_reg[k-1];
                ny_d_reg[k] <= ny_d_reg[k-1];
            end
            for (int c = 0; c < 2; c++) begin
                logic [ROOT_W-1:0] r;
                logic signed [15:0] n;
                r = (c == 0) ? root_x : root_y;
                n = (c == 0) ? nx_d_reg[SQ_LAT-1] : ny_d_reg[SQ_LAT-1];
                xx_reg[c][0] <= CV_W'($signed({1'b0, r}));
                yy_reg[c][0] <= CV_W'(n) <<< 8;
                aa_reg[c][0] <= '0;
                zr_reg[c][0] <= {(r == '0), 1'b0};
                nn_reg[c][0] <= n;
                for (int i = 0; i < NSTAGES; i++) begin
                    logic signed [CV_W-1:0] dx, dy;
                    dx = yy_reg[c][i] >>> i;
                    dy = xx_reg[c][i] >>> i;
                    if (!yy_reg[c][i][CV_W-1]) begin
                        xx_reg[c][i+1] <= xx_reg[c][i] + dx;
                        yy_reg[c][i+1] <= yy_reg[c][i] - dy;
                        aa_reg[c][i+1] <= aa_reg[c][i] + $signed(ATAN_Q30[i]);
                    end else begin
                        xx_reg[c][i+1] <= xx_reg[c][i] - dx;
                        yy_reg[c][i+1] <= yy_reg[c][i] + dy;
                        aa_reg[c][i+1] <= aa_reg[c][i] - $signed(ATAN_Q30[i]);
                    end
                    zr_reg[c][i+1] <= zr_reg[c][i];
                    nn_reg[c][i+1] <= nn_reg[c][i];
                end
                // magnitude, scale, round and saturate
                neg_reg[c] <= aa_reg[c][NSTAGES][ANG_W-1];
                mag_reg[c] <= aa_reg[c][NSTAGES][ANG_W-1]
                              ? MAG_W'(-aa_reg[c][NSTAGES]) : MAG_W'(aa_reg[c][NSTAGES]);
                zd_reg[c]  <= zr_reg[c][NSTAGES][1];
                nf_reg[c]  <= nn_reg[c][NSTAGES];
                prod_reg[c] <= 60'(mag_reg[c]) * 60'(DEG_SCALE);
                neg2_reg[c] <= neg_reg[c];
                zd2_reg[c]  <= zd_reg[c];
                nf2_reg[c]  <= nf_reg[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            logic [14:0] h [2];
            logic signed [TILT_W-1:0] t [2];
            for (int c = 0; c < 2; c++) begin
                logic [13:0] hh;
                hh = 14'((prod_reg[c] + (60'd1 << (DEG_SHIFT - 1))) >> DEG_SHIFT);
                h[c] = (hh > 14'(ANGLE_LIMIT)) ? 15'(ANGLE_LIMIT) : {1'b0, hh};
                if (zd2_reg[c]) begin
                    t[c] = (nf2_reg[c] > 0) ? TILT_W'(ANGLE_LIMIT)
                         : (nf2_reg[c] < 0) ? -TILT_W'(ANGLE_LIMIT) : '0;
                end else begin
                    t[c] = neg2_reg[c] ? -$signed(h[c]) : $signed(h[c]);
                end
            end
            res_reg.tilt_x <= t[0];
            res_reg.tilt_y <= t[1];
        end
    end

    assign out_valid = ov_reg;
    assign out_res   = o_reg;
endmodule

@@ sv/accel_tilt_angles.sv @@
// ----------------------------------------------------------------------------
// Accelerometer tilt angles
// Two tilt angles per raw three-axis sample, via root and vectoring rotation.
// ----------------------------------------------------------------------------
// One item in, one item out, one item per clock sustained while the output is
// not stalled. With 16 rotation stages an item passes 49 register stages: the
// front-end squares and sums, an entry in the two-entry queue, the input
// register plus 24 stages of the bit-per-stage square root, the start vector
// and one per rotation stage, magnitude, scaling and rounding, and the output
// register. Most of them lie in the root and rotation pipelines. Angles are
// hundredths of a degree, -9000..9000; a zero denominator gives +/-9000 by
// the numerator's sign, or 0.
module accel_tilt_angles (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // tilt_x [14:0], tilt_y [29:15], zeros [31:30]
);
    import acctilt_pkg::*;

    logic        f_valid, f_ready, q_valid, q_ready;
    front_item_t f_item, q_item;
    result_t     res;

    // front: accept and form the sums of squares
    acctilt_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .ax(s_tdata[15:0]), .ay(s_tdata[31:16]), .az(s_tdata[47:32]),
        .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
    );

    // queue: let either side stall alone
    acctilt_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    // back: root, rotation, conversion, output skid
    acctilt_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {2'b00, res.tilt_y, res.tilt_x};

    // results stay within the angle range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd9000
                      && $signed(m_tdata[14:0]) >= -15'sd9000))
        else $error("tilt_x out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[29:15]) <= 15'sd9000
                      && $signed(m_tdata[29:15]) >= -15'sd9000))
        else $error("tilt_y out of range");

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");
endmodule

@@ test/tilt_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt angle checker
// Watches both channels, predicts the two angles of every accepted sample and
// compares each accepted result item with the oldest prediction.
// ----------------------------------------------------------------------------
module tilt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          angles_pending
);
    import acctilt_pkg::*;

    localparam longint unsigned SCALE = 64'd375493621;

    result_t angle_q[$];

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [TILT_W-1:0] tilt_angle(longint num, longint a, longint b);
        longint unsigned r, mag, h;
        longint vx, vy, acc, dx, dy;
        r = int_root(longint'(a * a + b * b) << 16);
        if (r == 0)
            return num > 0 ? TILT_W'(ANGLE_LIMIT) : (num < 0 ? -TILT_W'(ANGLE_LIMIT) : '0);
        vx = longint'(r);
        vy = num * 256;
        acc = 0;
        for (int i = 0; i < NSTAGES; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx += dx; vy -= dy; acc += longint'(ATAN_Q30[i]);
            end else begin
                vx -= dx; vy += dy; acc -= longint'(ATAN_Q30[i]);
            end
        end
        mag = longint'(acc < 0 ? -acc : acc);
        h = (mag * SCALE + (64'd1 << 45)) >> 46;
        if (h > ANGLE_LIMIT) h = ANGLE_LIMIT;
        return acc < 0 ? -TILT_W'(h) : TILT_W'(h);
    endfunction

    task automatic report(string what, int got, int want);
        $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count     = 0;
        angles_pending = 0;
    end

    always @(posedge aclk) begin
        result_t want, got;
        longint ax, ay, az;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                ax = longint'($signed(s_tdata[15:0]));
                ay = longint'($signed(s_tdata[31:16]));
                az = longint'($signed(s_tdata[47:32]));
                want.tilt_x = tilt_angle(ax, ay, az);
                want.tilt_y = tilt_angle(ay, ax, az);
                angle_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.tilt_x = m_tdata[14:0];
                got.tilt_y = m_tdata[29:15];
                if (angle_q.size() == 0) begin
                    $display("%0t unexpected result item", $time);
                    fail_count++;
                end else begin
                    want = angle_q.pop_front();
                    if (got.tilt_x !== want.tilt_x) report("tilt_x", got.tilt_x, want.tilt_x);
                    if (got.tilt_y !== want.tilt_y) report("tilt_y", got.tilt_y, want.tilt_y);
                    if (m_tdata[31:30] !== 2'b00) report("pad", m_tdata[31:30], 0);
                end
            end
        end
        angles_pending <= angle_q.size();
    end
endmodule

@@ test/tb_accel_tilt_angles.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt angle testbench
// Drives directed corner samples, then random and well-tilted samples, with
// random gaps on both sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_accel_tilt_angles;
    localparam int WATCHDOG = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          angles_pending;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;

    always #5 aclk = ~aclk;

    accel_tilt_angles u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata
    );

    tilt_checker u_check (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .fail_count, .angles_pending
    );

    // Send one sample: drop valid for a random gap first, then hold it until the handshake.
    // Ready only moves at the rising edge, so read it at the falling edge.
    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        while (!s_tready) @(negedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'(int'($urandom_range(0, 8)) - 4);
            1: return 16'h8000 + 16'($urandom_range(0, 2));
            2: return 16'h7FFF - 16'($urandom_range(0, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: hold ready low for a random stall, or none, before each result item.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            while (!m_tvalid) @(negedge aclk);
            @(negedge aclk);
        end
    end

    // Watchdog: count cycles with no accepted item on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else if (!stim_done || angles_pending != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("accel_tilt_angles regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] g;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: all zero, single-axis extremes, zero denominators, equal axes.
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h7FFF, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h0000, 16'h0000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000, 16'h8000);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000, 16'h0000);
        send_sample(16'h0001, 16'hFFFF, 16'h0000);
        send_sample(16'h0001, 16'h0001, 16'h0001);
        send_sample(16'hFFFF, 16'hFFFF, 16'h0001);
        send_sample(16'h0064, 16'h0064, 16'h0000);
        send_sample(16'h4000, 16'hC000, 16'h4000);
        send_sample(16'hFFFF, 16'h0001, 16'h7FFF);

        // Pause until the pipeline has drained completely.
        s_tvalid <= 1'b0;
        while (angles_pending != 0) @(negedge aclk);

        for (int n = 0; n < 1200; n++) begin
            if (n % 3 == 0) begin
                // Realistic gravity vector: one big axis, two small tilted ones.
                g = 16'($urandom_range(2000, 30000));
                send_sample(16'($signed(16'($urandom_range(0, 8000))) - 16'sd4000),
                            16'($signed(16'($urandom_range(0, 8000))) - 16'sd4000),
                            $urandom_range(0, 1) ? g : -g);
            end else begin
                send_sample(rand_axis(), rand_axis(), rand_axis());
            end
            // Let valid stay high into the next item by not lowering it here.
            if (n == 600) begin
                s_tvalid <= 1'b0;
                while (angles_pending != 0) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (angles_pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (fail_count == 0)
            $display("accel_tilt_angles regression: pass");
        else
            $display("accel_tilt_angles regression: fail");
        $finish;
    end
endmodule
